// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the autokey cipher RTL.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Overlapping implication: cons must hold in the cycle where ante holds.
`define AKC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("akc assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define AKC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("akc assertion failed");
`else
`define AKC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AKC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/akc_pkg.sv =====
// Shared types and constants for the autokey cipher unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package akc_pkg;

    // Longest initial key, and the plaintext history depth
    localparam int KEY_MAX  = 16;
    localparam int HIST_AW  = $clog2(KEY_MAX);
    localparam int POS_W    = $clog2(KEY_MAX + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW   = 64;

    // Queue between front and back
    localparam int QDEPTH   = 2;

    // Character constants
    localparam logic [7:0] CH_LA = 8'h61;  // 'a'
    localparam logic [7:0] CH_LZ = 8'h7A;  // 'z'
    localparam logic [7:0] CH_UA = 8'h41;  // 'A'
    localparam logic [7:0] CH_UZ = 8'h5A;  // 'Z'
    localparam logic [5:0] ALPHA = 6'd26;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION  = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_KEY_LOW    = 2'd2,
        CFG_KEY_HIGH   = 2'd3
    } t_cfg_idx;

    // Configuration as seen by front and back
    typedef struct packed {
        logic                      decrypt;
        logic [POS_W-1:0]          eff_len;    // 1..KEY_MAX
        logic [KEY_MAX-1:0][7:0]   key_chars;  // char 0 in entry 0
    } t_cfg;

    // One classified byte waiting for the back end
    typedef struct packed {
        logic [7:0]         text;
        logic               use_key;   // key char from config, else history
        logic [7:0]         key_char;
        logic [HIST_AW-1:0] rd_idx;    // history entry holding the key char
        logic [HIST_AW-1:0] wr_idx;    // history entry for this plaintext
    } t_job;

endpackage

// ===== hdl/akc_front.sv =====
// Front end: accepts input beats, tracks message position and ring pointer,
// and classifies each byte's key source. Depends on akc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module akc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  akc_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic [7:0]      i_text,
    input  logic            i_start,
    output akc_pkg::t_job   o_job
);
    import akc_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [HIST_AW-1:0] r_rp, n_rp;
    logic [POS_W-1:0]   pos_cur;

    // Position of this byte within its message
    assign pos_cur = i_start ? '0 : r_pos;

    // Job fields
    always_comb begin
        o_job.text     = i_text;
        o_job.use_key  = (pos_cur < i_cfg.eff_len);
        o_job.key_char = i_cfg.key_chars[pos_cur[HIST_AW-1:0]];
        o_job.rd_idx   = r_rp - i_cfg.eff_len[HIST_AW-1:0];
        o_job.wr_idx   = r_rp;
    end

    // Position saturates at KEY_MAX; ring pointer wraps
    always_comb begin
        n_pos = r_pos;
        n_rp  = r_rp;
        if (i_accept) begin
            n_pos = (pos_cur < POS_W'(KEY_MAX)) ? pos_cur + 1'b1 : pos_cur;
            n_rp  = r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_rp  <= '0;
        end else begin
            r_pos <= n_pos;
            r_rp  <= n_rp;
        end
    end

    `AKC_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(KEY_MAX))
    `AKC_ASSERT_NXT(a_rp_step, i_clk, i_rst_n, i_accept, r_rp == ($past(r_rp) + 1'b1))

endmodule

// ===== hdl/akc_queue.sv =====
// Short FIFO of classified jobs between front and back ends.
// Depends on akc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module akc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  akc_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output akc_pkg::t_job   o_job
);
    import akc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    `AKC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QDEPTH))
    `AKC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)

endmodule

// ===== hdl/akc_back.sv =====
// Back end: resolves the key char, shifts the byte, updates the plaintext
// history and holds the output register. Depends on akc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module akc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  akc_pkg::t_cfg   i_cfg,
    input  logic            i_job_valid,
    input  akc_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_text_out
);
    import akc_pkg::*;

    logic [7:0] r_hist [KEY_MAX];
    logic       r_out_valid;
    logic [7:0] r_text_out;

    logic [7:0] key;
    logic [4:0] shift;
    logic       is_lower, is_upper;
    logic [7:0] base;
    logic [5:0] off, sum, wrapped;
    logic [7:0] res, plain;

    // Take a job when the output register is free or being drained
    assign o_pop = i_job_valid && (!r_out_valid || i_out_ready);

    // Key char, then its shift amount
    always_comb begin
        key   = i_job.use_key ? i_job.key_char : r_hist[i_job.rd_idx];
        shift = '0;
        if (key >= CH_LA && key <= CH_LZ) begin
            shift = 5'(key - CH_LA);
        end else if (key >= CH_UA && key <= CH_UZ) begin
            shift = 5'(key - CH_UA);
        end
    end

    // Shift within the byte's own case, mod 26
    always_comb begin
        is_lower = (i_job.text >= CH_LA) && (i_job.text <= CH_LZ);
        is_upper = (i_job.text >= CH_UA) && (i_job.text <= CH_UZ);
        base     = is_lower ? CH_LA : CH_UA;
        off      = 6'(i_job.text - base);
        if (i_cfg.decrypt) begin
            sum = off + ALPHA - {1'b0, shift};
        end else begin
            sum = off + {1'b0, shift};
        end
        wrapped = (sum >= ALPHA) ? sum - ALPHA : sum;
        res     = (is_lower || is_upper) ? base + {2'b00, wrapped} : i_job.text;
        plain   = i_cfg.decrypt ? res : i_job.text;
    end

    // Plaintext history ring
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hist[i_job.wr_idx] <= plain;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_text_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_text_out  = r_text_out;

    `AKC_ASSERT_NXT(a_pop_fills, i_clk, i_rst_n, o_pop, r_out_valid)

endmodule

// ===== hdl/autokey_cipher_unit.sv =====
// Top level of the autokey cipher unit: configuration registers, front end,
// job queue and back end. Depends on akc_pkg, akc_front, akc_queue, akc_back.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     i_text_in, i_message_start
//   output    out        o_out_valid / i_out_ready   o_text_out
//   config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while i_out_ready is high; o_out_valid rises after
// the queue registers the job and back resolves and registers the result.
// The back end reads and writes the 16-entry plaintext ring once per byte.
// Reset is synchronous, active low; no clearing pass is needed.
// An output stall fills the two-entry queue, then drops o_in_ready.
`timescale 1ns / 1ps

module autokey_cipher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_text_in,
    input  logic                             i_message_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_text_out,
    input  logic                             i_cfg_we,
    input  logic [akc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [akc_pkg::CFG_DW-1:0]       i_cfg_data
);
    import akc_pkg::*;

    logic              r_direction;
    logic [4:0]        r_key_length;
    logic [63:0]       r_key_low, r_key_high;
    t_cfg              cfg;

    logic              q_full, q_valid, accept, pop;
    t_job              front_job, back_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_key_length <= 5'd1;
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIRECTION:  r_direction  <= i_cfg_data[0];
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[4:0];
                CFG_KEY_LOW:    r_key_low    <= i_cfg_data[63:0];
                CFG_KEY_HIGH:   r_key_high   <= i_cfg_data[63:0];
            endcase
        end
    end

    // Effective key length clamped to 1..KEY_MAX
    always_comb begin
        cfg.decrypt   = r_direction;
        cfg.key_chars = {r_key_high, r_key_low};
        if (r_key_length == '0) begin
            cfg.eff_len = POS_W'(1);
        end else if (r_key_length > 5'(KEY_MAX)) begin
            cfg.eff_len = POS_W'(KEY_MAX);
        end else begin
            cfg.eff_len = POS_W'(r_key_length);
        end
    end

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    akc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_accept(accept),
        .i_text  (i_text_in),
        .i_start (i_message_start),
        .o_job   (front_job)
    );

    akc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    akc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_text_out  (o_text_out)
    );

endmodule
